[sv/vpls_pkg.sv]
// Shared types and constants for the point-light vertex shader.
package vpls_pkg;

  localparam int unsigned MaxLights = 8;
  localparam int unsigned SlotW     = $clog2(MaxLights);
  localparam int unsigned CntW      = $clog2(MaxLights + 1);
  localparam int unsigned CfgW      = 4;
  localparam logic [12:0] AmbientQ15 = 13'd6554;
  localparam logic [16:0] OneQ15     = 17'd32768;
  localparam logic [5:0]  EpsSq      = 6'd49;
  localparam int unsigned InW  = 1 + 3 * 32 + 6 * 16 + 31 + 16;
  localparam int unsigned InTW = ((InW + 7) / 8) * 8;
  localparam int unsigned OutTW = 48;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SHADE = 1'b1
  } op_e;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [30:0] reach;
    logic [15:0] power;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } light_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } vert_t;

  // One vertex-light pair on its way down the light pipeline.
  typedef struct packed {
    logic        first;
    logic        last;
    logic        skip;
    vert_t       vtx;
    light_t      lgt;
  } pair_t;

endpackage

[sv/vertex_point_light_shader_unit.sv]
// Top level of the per-vertex point-light shader.
//
// Slave stream s_axis_*: one word per item; opcode is tuser, the rest is tdata.
// A load word stores a light at the wrapping load pointer and gives no result.
// A shade word gives one result word on m_axis_*: lit red, green, blue.
// active_lights is written through cfg_we_i / cfg_wdata_i; the user writes it
// only while idle, as the block itself does not enforce this.
// A shade word is issued as n = max(min(active_lights,8),1) vertex-light pairs,
// one per cycle while not stalled, into a deep pipeline (square root, then two
// 64-stage dividers, then four multiply stages); no new word is taken until
// all pairs of a shade word have issued, but a load word does not block it.
// A shade word with no active lights still runs one dummy pair.
// The pipeline stalls as a whole while the output register holds an untaken
// word; nothing is lost or repeated. Reset clears the load pointer, the
// register, the sequencer and all valid bits; light slots hold garbage until
// loaded.
module vertex_point_light_shader_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vpls_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, red, green, blue,
  // light_range, light_intensity (lowest first), zero padded
  input  logic [vpls_pkg::InTW-1:0] s_axis_tdata,
  input  logic                      s_axis_tuser,   // opcode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [vpls_pkg::OutTW-1:0] m_axis_tdata   // lit_red, lit_green, lit_blue
);
  import vpls_pkg::*;

  logic [CfgW-1:0] act_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) act_q <= '0;
    else if (cfg_we_i) act_q <= cfg_wdata_i;
  end
  logic [CntW-1:0] nl;
  assign nl = (act_q > CfgW'(MaxLights)) ? CntW'(MaxLights) : CntW'(act_q);

  // Unpack input word.
  vert_t  vin;
  light_t lin;
  assign vin.px = s_axis_tdata[31:0];
  assign vin.py = s_axis_tdata[63:32];
  assign vin.pz = s_axis_tdata[95:64];
  assign vin.nx = s_axis_tdata[111:96];
  assign vin.ny = s_axis_tdata[127:112];
  assign vin.nz = s_axis_tdata[143:128];
  assign vin.r  = s_axis_tdata[159:144];
  assign vin.g  = s_axis_tdata[175:160];
  assign vin.b  = s_axis_tdata[191:176];
  assign lin.px = s_axis_tdata[31:0];
  assign lin.py = s_axis_tdata[63:32];
  assign lin.pz = s_axis_tdata[95:64];
  assign lin.r  = s_axis_tdata[159:144];
  assign lin.g  = s_axis_tdata[175:160];
  assign lin.b  = s_axis_tdata[191:176];
  assign lin.reach = s_axis_tdata[222:192];
  assign lin.power = s_axis_tdata[238:223];

  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready;

  // Light slots.
  light_t lights_q [MaxLights];
  logic [SlotW-1:0] ld_ptr_q;

  // Sequencer: holds one vertex while its pairs issue.
  logic busy_q;
  vert_t vtx_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] cnt_q;
  logic acc_in;
  assign s_axis_tready = en && !busy_q;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_ptr_q <= '0;
      busy_q   <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (acc_in && s_axis_tuser == OP_LOAD) ld_ptr_q <= SlotW'((CntW'(ld_ptr_q) + 1'b1) % CntW'(MaxLights));
      if (en) begin
        if (acc_in && s_axis_tuser == OP_SHADE) begin
          busy_q <= 1'b1;
          idx_q  <= '0;
          cnt_q  <= (nl == '0) ? CntW'(1) : nl;
        end else if (busy_q) begin
          if (idx_q + 1'b1 >= cnt_q) busy_q <= 1'b0;
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (acc_in && s_axis_tuser == OP_LOAD) lights_q[ld_ptr_q] <= lin;
    if (acc_in && s_axis_tuser == OP_SHADE) vtx_q <= vin;
  end

  pair_t pr;
  always_comb begin
    pr.first = (idx_q == '0);
    pr.last  = (idx_q + 1'b1 >= cnt_q);
    pr.skip  = (nl == '0);
    pr.vtx   = vtx_q;
    pr.lgt   = lights_q[idx_q[SlotW-1:0]];
  end

  logic p_v, p_first, p_last;
  vert_t p_vtx;
  logic [16:0] t_r, t_g, t_b;
  vpls_light_pipe u_pipe (
    .clk_i, .rst_ni,
    .en_i     (en),
    .vld_i    (busy_q),
    .pair_i   (pr),
    .vld_o    (p_v),
    .first_o  (p_first),
    .last_o   (p_last),
    .vtx_o    (p_vtx),
    .term_r_o (t_r),
    .term_g_o (t_g),
    .term_b_o (t_b)
  );

  // Accumulate terms; start from ambient on the first pair.
  logic [16:0] sr_q, sg_q, sb_q;
  logic [16:0] br, bg, bb, nr, ng, nb;
  logic [17:0] xr, xg, xb;
  always_comb begin
    br = p_first ? 17'((29'(p_vtx.r) * 29'(AmbientQ15)) >> 15) : sr_q;
    bg = p_first ? 17'((29'(p_vtx.g) * 29'(AmbientQ15)) >> 15) : sg_q;
    bb = p_first ? 17'((29'(p_vtx.b) * 29'(AmbientQ15)) >> 15) : sb_q;
    xr = 18'(br) + 18'(t_r);
    xg = 18'(bg) + 18'(t_g);
    xb = 18'(bb) + 18'(t_b);
    nr = (xr > 18'(OneQ15)) ? OneQ15 : xr[16:0];
    ng = (xg > 18'(OneQ15)) ? OneQ15 : xg[16:0];
    nb = (xb > 18'(OneQ15)) ? OneQ15 : xb[16:0];
  end
  logic [15:0] or_q, og_q, ob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= p_v && p_last;
  end
  // Sums are capped at 32768, so the low 16 bits carry the whole value.
  always_ff @(posedge clk_i) begin
    if (en && p_v) begin
      sr_q <= nr; sg_q <= ng; sb_q <= nb;
      or_q <= nr[15:0]; og_q <= ng[15:0]; ob_q <= nb[15:0];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {ob_q, og_q, or_q};
endmodule

[sv/vpls_sqrt.sv]
// Pipelined integer square root, two result bits per stage.
module vpls_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [65:0] rad_i,
  output logic [32:0] root_o
);
  import vpls_pkg::*;

  localparam int unsigned NSt = 17;
  logic [67:0] rem_q [NSt+1];
  logic [33:0] res_q [NSt+1];
  logic [67:0] val_q [NSt+1];

  always_comb begin
    rem_q[0] = '0;
    res_q[0] = '0;
    val_q[0] = {2'b00, rad_i};
  end

  for (genvar s = 0; s < NSt; s++) begin : g_st
    logic [67:0] rem_d;
    logic [33:0] res_d;
    logic [67:0] val_d;
    always_comb begin
      logic [67:0] r2;
      logic [67:0] t1, t2;
      logic [33:0] q;
      r2 = rem_q[s];
      q  = res_q[s];
      val_d = val_q[s];
      for (int k = 0; k < 2; k++) begin
        r2 = {r2[65:0], val_d[67:66]};
        val_d = {val_d[65:0], 2'b00};
        t1 = {32'd0, q, 2'b01};
        if (r2 >= t1) begin
          r2 = r2 - t1;
          q  = {q[32:0], 1'b1};
        end else begin
          q  = {q[32:0], 1'b0};
        end
      end
      t2 = r2;
      rem_d = t2;
      res_d = q;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[s+1] <= '0;
        res_q[s+1] <= '0;
        val_q[s+1] <= '0;
      end else if (en_i) begin
        rem_q[s+1] <= rem_d;
        res_q[s+1] <= res_d;
        val_q[s+1] <= val_d;
      end
    end
  end

  assign root_o = res_q[NSt][32:0];
endmodule

[sv/vpls_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module vpls_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [47:0] den_i,
  output logic [63:0] quo_o
);
  import vpls_pkg::*;

  localparam int unsigned NB = 64;
  logic [63:0] num_q [NB+1];
  logic [48:0] rem_q [NB+1];
  logic [47:0] den_q [NB+1];

  always_comb begin
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
  end

  for (genvar s = 0; s < NB; s++) begin : g_st
    logic [48:0] sh;
    logic [48:0] rem_d;
    logic [63:0] num_d;
    always_comb begin
      sh = {rem_q[s][47:0], num_q[s][63]};
      num_d = {num_q[s][62:0], 1'b0};
      if (sh >= {1'b0, den_q[s]}) begin
        rem_d = sh - {1'b0, den_q[s]};
        num_d[0] = 1'b1;
      end else begin
        rem_d = sh;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        num_q[s+1] <= '0;
        rem_q[s+1] <= '0;
        den_q[s+1] <= '0;
      end else if (en_i) begin
        num_q[s+1] <= num_d;
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign quo_o = num_q[NB];
endmodule

[sv/vpls_light_pipe.sv]
// Per-pair lighting pipeline: distance, tests, sqrt, divides, color terms.
module vpls_light_pipe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  vpls_pkg::pair_t      pair_i,
  output logic                 vld_o,
  output logic                 first_o,
  output logic                 last_o,
  output vpls_pkg::vert_t      vtx_o,
  output logic [16:0]          term_r_o,
  output logic [16:0]          term_g_o,
  output logic [16:0]          term_b_o
);
  import vpls_pkg::*;

  // Stage 1: axis deltas.
  logic        s1_v_q;
  pair_t       s1_p_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en_i) s1_v_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_p_q <= pair_i;
      dx_q <= 33'($signed(pair_i.lgt.px)) - 33'(pair_i.vtx.px);
      dy_q <= 33'($signed(pair_i.lgt.py)) - 33'(pair_i.vtx.py);
      dz_q <= 33'($signed(pair_i.lgt.pz)) - 33'(pair_i.vtx.pz);
    end
  end

  // Stage 2: magnitudes, squares, dot products, range squared.
  logic [32:0] ax, ay, az;
  assign ax = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ay = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign az = dz_q[32] ? 33'(-dz_q) : 33'(dz_q);
  logic s2_v_q;
  pair_t s2_p_q;
  logic [65:0] sx_q, sy_q, sz_q;
  logic signed [49:0] tx_q, ty_q, tz_q;
  logic [61:0] r2_q;
  logic range_bad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en_i) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_p_q <= s1_p_q;
      sx_q <= 66'(ax) * 66'(ax);
      sy_q <= 66'(ay) * 66'(ay);
      sz_q <= 66'(az) * 66'(az);
      tx_q <= 50'(s1_p_q.vtx.nx) * 50'(dx_q);
      ty_q <= 50'(s1_p_q.vtx.ny) * 50'(dy_q);
      tz_q <= 50'(s1_p_q.vtx.nz) * 50'(dz_q);
      r2_q <= 62'(s1_p_q.lgt.reach) * 62'(s1_p_q.lgt.reach);
      range_bad_q <= (ax > 33'(s1_p_q.lgt.reach)) || (ay > 33'(s1_p_q.lgt.reach)) ||
                     (az > 33'(s1_p_q.lgt.reach));
    end
  end

  // Stage 3: sums and skip tests.
  logic [65:0] d2_c;
  logic signed [51:0] dot_c;
  assign d2_c  = sx_q + sy_q + sz_q;
  assign dot_c = 52'(tx_q) + 52'(ty_q) + 52'(tz_q);
  pair_t s3_p_c;
  always_comb begin
    s3_p_c      = s2_p_q;
    s3_p_c.skip = s2_p_q.skip || range_bad_q || (d2_c < 66'(EpsSq)) ||
                  (d2_c > 66'(r2_q)) || (dot_c <= 52'sd0);
  end
  logic s3_v_q;
  pair_t s3_p_q;
  logic [65:0] d2_q;
  logic [61:0] r2b_q;
  logic [50:0] dot_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en_i) s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_p_q <= s3_p_c;
      d2_q  <= d2_c;
      r2b_q <= r2_q;
      dot_q <= dot_c[50:0];
    end
  end

  // Stage 4: normalize range squared below 2^47, build dividend.
  logic [5:0] sh_c;
  always_comb begin
    sh_c = '0;
    for (int k = 47; k < 62; k++) begin
      if (r2b_q[k]) sh_c = 6'(k - 46);
    end
  end
  logic s4_v_q;
  pair_t s4_p_q;
  logic [65:0] d2b_q;
  logic [50:0] dotb_q;
  logic [63:0] anum_q;
  logic [47:0] aden_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en_i) s4_v_q <= s3_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_p_q <= s3_p_q;
      d2b_q  <= d2_q;
      dotb_q <= dot_q;
      aden_q <= (r2b_q == '0) ? 48'd1 : 48'(r2b_q >> sh_c);
      // unused when skipped, so wrap of r2-d2 is harmless
      anum_q <= {16'd0, 48'((62'(r2b_q - 62'(d2_q))) >> sh_c)} << 16;
    end
  end

  // Square root of d2 (17 stages), then divide for ndotl.
  // Attenuation divide starts after the sqrt to share the same delay.
  localparam int unsigned SqD = 17;
  logic [32:0] root;
  vpls_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i,
    .rad_i  (d2b_q),
    .root_o (root)
  );
  logic  dv_q [SqD];
  pair_t dp_q [SqD];
  logic [50:0] dd_q [SqD];
  logic [63:0] an_q [SqD];
  logic [47:0] ad_q [SqD];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqD; k++) dv_q[k] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= s4_v_q;
      for (int k = 1; k < SqD; k++) dv_q[k] <= dv_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp_q[0] <= s4_p_q; dd_q[0] <= dotb_q; an_q[0] <= anum_q; ad_q[0] <= aden_q;
      for (int k = 1; k < SqD; k++) begin
        dp_q[k] <= dp_q[k-1]; dd_q[k] <= dd_q[k-1];
        an_q[k] <= an_q[k-1]; ad_q[k] <= ad_q[k-1];
      end
    end
  end

  logic [63:0] nq, aq;
  logic [47:0] rden;
  assign rden = (root == '0) ? 48'd1 : 48'(root);
  vpls_div u_div_n (
    .clk_i, .rst_ni, .en_i,
    .num_i ({13'd0, dd_q[SqD-1]}),
    .den_i (rden),
    .quo_o (nq)
  );
  vpls_div u_div_a (
    .clk_i, .rst_ni, .en_i,
    .num_i (an_q[SqD-1]),
    .den_i (ad_q[SqD-1]),
    .quo_o (aq)
  );
  localparam int unsigned DvD = 64;
  logic  ev_q [DvD];
  pair_t ep_q [DvD];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DvD; k++) ev_q[k] <= 1'b0;
    end else if (en_i) begin
      ev_q[0] <= dv_q[SqD-1];
      for (int k = 1; k < DvD; k++) ev_q[k] <= ev_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ep_q[0] <= dp_q[SqD-1];
      for (int k = 1; k < DvD; k++) ep_q[k] <= ep_q[k-1];
    end
  end

  // Color stage A: clamp ndotl, atten = a*a >> 16; base*col >> 15.
  logic [16:0] a17;
  assign a17 = (aq > 64'd65536) ? 17'd65536 : aq[16:0];
  logic ca_v_q;
  pair_t ca_p_q;
  logic [15:0] nd_q;
  logic [16:0] at_q;
  logic [16:0] cr_q, cg_q, cb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ca_v_q <= 1'b0;
    else if (en_i) ca_v_q <= ev_q[DvD-1];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_p_q <= ep_q[DvD-1];
      nd_q <= (nq > 64'hFFFF) ? 16'hFFFF : nq[15:0];
      at_q <= 17'((34'(a17) * 34'(a17)) >> 16);
      cr_q <= 17'((32'(ep_q[DvD-1].vtx.r) * 32'(ep_q[DvD-1].lgt.r)) >> 15);
      cg_q <= 17'((32'(ep_q[DvD-1].vtx.g) * 32'(ep_q[DvD-1].lgt.g)) >> 15);
      cb_q <= 17'((32'(ep_q[DvD-1].vtx.b) * 32'(ep_q[DvD-1].lgt.b)) >> 15);
    end
  end

  // Color stage B: times intensity >> 8.
  logic cb_v_q;
  pair_t cbp_q;
  logic [15:0] nd2_q;
  logic [16:0] at2_q;
  logic [24:0] ir_q, ig_q, ib_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cb_v_q <= 1'b0;
    else if (en_i) cb_v_q <= ca_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cbp_q <= ca_p_q; nd2_q <= nd_q; at2_q <= at_q;
      ir_q <= 25'((33'(cr_q) * 33'(ca_p_q.lgt.power)) >> 8);
      ig_q <= 25'((33'(cg_q) * 33'(ca_p_q.lgt.power)) >> 8);
      ib_q <= 25'((33'(cb_q) * 33'(ca_p_q.lgt.power)) >> 8);
    end
  end

  // Color stage C: times atten >> 16.
  logic cc_v_q;
  pair_t ccp_q;
  logic [15:0] nd3_q;
  logic [25:0] ur_q, ug_q, ub_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cc_v_q <= 1'b0;
    else if (en_i) cc_v_q <= cb_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ccp_q <= cbp_q; nd3_q <= nd2_q;
      ur_q <= 26'((42'(ir_q) * 42'(at2_q)) >> 16);
      ug_q <= 26'((42'(ig_q) * 42'(at2_q)) >> 16);
      ub_q <= 26'((42'(ib_q) * 42'(at2_q)) >> 16);
    end
  end

  // Color stage D: times ndotl >> 14, clamp to a 17 bit term (sum saturates anyway).
  logic [41:0] wr, wg, wb;
  assign wr = (42'(ur_q) * 42'(nd3_q)) >> 14;
  assign wg = (42'(ug_q) * 42'(nd3_q)) >> 14;
  assign wb = (42'(ub_q) * 42'(nd3_q)) >> 14;
  logic cd_v_q;
  pair_t cdp_q;
  logic [16:0] tr_q, tg_q, tb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cd_v_q <= 1'b0;
    else if (en_i) cd_v_q <= cc_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cdp_q <= ccp_q;
      tr_q <= ccp_q.skip ? '0 : ((wr > 42'(OneQ15)) ? OneQ15 : wr[16:0]);
      tg_q <= ccp_q.skip ? '0 : ((wg > 42'(OneQ15)) ? OneQ15 : wg[16:0]);
      tb_q <= ccp_q.skip ? '0 : ((wb > 42'(OneQ15)) ? OneQ15 : wb[16:0]);
    end
  end

  assign vld_o    = cd_v_q;
  assign first_o  = cdp_q.first;
  assign last_o   = cdp_q.last;
  assign vtx_o    = cdp_q.vtx;
  assign term_r_o = tr_q;
  assign term_g_o = tg_q;
  assign term_b_o = tb_q;
endmodule
